[design/ssdbm_pkg.sv]
// ----------------------------------------------------------------------------
// ssdbm_pkg
// Shared types and constants for the SSD block matcher with ratio test.
// ----------------------------------------------------------------------------
`default_nettype none

package ssdbm_pkg;

    localparam int PIX_W       = 8;
    localparam int SQ_W        = 2 * PIX_W;
    localparam int SUM_W       = 24;
    localparam int RATIO_W     = 16;
    localparam int PROD_W      = SUM_W + RATIO_W;
    localparam int CAND_W      = 10;
    localparam int QUERY_W     = 12;
    localparam int QDEPTH      = 4;
    localparam int QPTR_W      = $clog2(QDEPTH);
    localparam int QCNT_W      = QPTR_W + 1;
    localparam int S_TDATA_W   = 16;
    localparam int M_TDATA_W   = 72;
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;

    localparam logic [SUM_W-1:0]   SUM_MAX     = {SUM_W{1'b1}};
    localparam logic [SUM_W-1:0]   SSD_RESET   = {SUM_W{1'b1}};
    localparam logic [RATIO_W-1:0] RATIO_RESET = 16'd52429;

    // register index, taken from paddr[2]
    localparam logic REG_SSD_THRESHOLD   = 1'b0;
    localparam logic REG_RATIO_THRESHOLD = 1'b1;

    // one finished candidate window
    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic             last_cand;
    } window_t;

    typedef struct packed {
        logic empty;
        logic full;
    } queue_status_t;

endpackage

`default_nettype wire

[design/ssdbm_front.sv]
// ----------------------------------------------------------------------------
// ssdbm_front
// Takes pixel pairs, accumulates the saturating squared-difference sum of
// the current candidate window and pushes each finished window to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module ssdbm_front
    import ssdbm_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [PIX_W-1:0]   query_pixel,
    input  wire logic [PIX_W-1:0]   candidate_pixel,
    input  wire logic               last_pixel,
    input  wire logic               last_candidate,
    input  wire queue_status_t      q_status,
    output logic                    q_push,
    output window_t                 q_wdata
);

    logic [SUM_W-1:0] window_sum_reg;
    logic [SUM_W-1:0] window_sum_next;
    logic signed [PIX_W:0] diff;
    logic [SQ_W-1:0]  sq;
    logic [SUM_W:0]   acc;
    logic [SUM_W-1:0] sat_sum;
    logic             take;

    assign s_tready = !q_status.full;
    assign take     = s_tvalid && s_tready;

    always_comb begin
        diff    = $signed({1'b0, candidate_pixel}) - $signed({1'b0, query_pixel});
        sq      = SQ_W'(diff * diff);
        acc     = {1'b0, window_sum_reg} + {{(SUM_W + 1 - SQ_W){1'b0}}, sq};
        sat_sum = acc[SUM_W] ? SUM_MAX : acc[SUM_W-1:0];
    end

    assign q_push            = take && last_pixel;
    assign q_wdata.sum       = sat_sum;
    assign q_wdata.last_cand = last_candidate;

    always_comb begin
        window_sum_next = window_sum_reg;
        if (take) begin
            window_sum_next = last_pixel ? '0 : sat_sum;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_sum_reg <= '0;
        end else begin
            window_sum_reg <= window_sum_next;
        end
    end

endmodule

`default_nettype wire

[design/ssdbm_queue.sv]
// ----------------------------------------------------------------------------
// ssdbm_queue
// Short FIFO of finished window sums between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module ssdbm_queue
    import ssdbm_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     push,
    input  wire window_t  wdata,
    input  wire logic     pop,
    output window_t       rdata,
    output queue_status_t status
);

    window_t           entry_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              do_push;
    logic              do_pop;

    assign status.empty = (count_reg == '0);
    assign status.full  = (count_reg == QCNT_W'(QDEPTH));
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign rdata        = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

[design/ssdbm_back.sv]
// ----------------------------------------------------------------------------
// ssdbm_back
// Ranks each finished window against best and second best, and after the
// final candidate runs the threshold and ratio tests in a short pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module ssdbm_back
    import ssdbm_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire window_t            q_rdata,
    input  wire queue_status_t      q_status,
    output logic                    q_pop,
    input  wire logic [SUM_W-1:0]   ssd_threshold,
    input  wire logic [RATIO_W-1:0] ratio_threshold,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [QUERY_W-1:0]      query_index,
    output logic                    match_found,
    output logic [CAND_W-1:0]       best_index,
    output logic [SUM_W-1:0]        best_sum,
    output logic [SUM_W-1:0]        second_sum
);

    // per-query ranking state
    logic [SUM_W-1:0]   best_reg,   best_next;
    logic [SUM_W-1:0]   second_reg, second_next;
    logic [CAND_W-1:0]  pos_reg,    pos_next;
    logic [CAND_W-1:0]  cand_reg,   cand_next;
    logic [QUERY_W-1:0] query_reg,  query_next;

    // stage A: final ranking of a query
    logic               a_valid_reg;
    logic [SUM_W-1:0]   a_best_reg, a_second_reg;
    logic [CAND_W-1:0]  a_pos_reg;
    logic [QUERY_W-1:0] a_query_reg;

    // stage B: products and threshold test
    logic               b_valid_reg;
    logic [PROD_W-1:0]  b_lhs_reg, b_rhs_reg;
    logic               b_thr_ok_reg;
    logic [SUM_W-1:0]   b_best_reg, b_second_reg;
    logic [CAND_W-1:0]  b_pos_reg;
    logic [QUERY_W-1:0] b_query_reg;

    // stage C: ratio compare and output register
    logic               c_valid_reg;
    logic               c_match_reg;
    logic [SUM_W-1:0]   c_best_reg, c_second_reg;
    logic [CAND_W-1:0]  c_pos_reg;
    logic [QUERY_W-1:0] c_query_reg;

    logic a_ready, b_ready, c_ready;
    logic finish;

    assign c_ready = !c_valid_reg || m_tready;
    assign b_ready = !b_valid_reg || c_ready;
    assign a_ready = !a_valid_reg || b_ready;

    assign q_pop  = !q_status.empty && (!q_rdata.last_cand || a_ready);
    assign finish = q_pop && q_rdata.last_cand;

    always_comb begin
        best_next   = best_reg;
        second_next = second_reg;
        pos_next    = pos_reg;
        if (q_rdata.sum < best_reg) begin
            second_next = best_reg;
            best_next   = q_rdata.sum;
            pos_next    = cand_reg;
        end else if (q_rdata.sum < second_reg) begin
            second_next = q_rdata.sum;
        end
        cand_next  = cand_reg + 1'b1;
        query_next = query_reg + 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            best_reg   <= SUM_MAX;
            second_reg <= SUM_MAX;
            pos_reg    <= '0;
            cand_reg   <= '0;
            query_reg  <= '0;
        end else if (q_pop) begin
            if (finish) begin
                best_reg   <= SUM_MAX;
                second_reg <= SUM_MAX;
                pos_reg    <= '0;
                cand_reg   <= '0;
                query_reg  <= query_next;
            end else begin
                best_reg   <= best_next;
                second_reg <= second_next;
                pos_reg    <= pos_next;
                cand_reg   <= cand_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end else begin
            if (a_ready) begin
                a_valid_reg <= finish;
            end
            if (b_ready) begin
                b_valid_reg <= a_valid_reg;
            end
            if (c_ready) begin
                c_valid_reg <= b_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (finish) begin
            a_best_reg   <= best_next;
            a_second_reg <= second_next;
            a_pos_reg    <= pos_next;
            a_query_reg  <= query_reg;
        end
        if (b_ready && a_valid_reg) begin
            b_lhs_reg    <= {a_best_reg, {RATIO_W{1'b0}}};
            b_rhs_reg    <= PROD_W'(ratio_threshold * a_second_reg);
            b_thr_ok_reg <= (a_best_reg < ssd_threshold) && (a_second_reg != '0);
            b_best_reg   <= a_best_reg;
            b_second_reg <= a_second_reg;
            b_pos_reg    <= a_pos_reg;
            b_query_reg  <= a_query_reg;
        end
        if (c_ready && b_valid_reg) begin
            c_match_reg  <= b_thr_ok_reg && (b_lhs_reg < b_rhs_reg);
            c_best_reg   <= b_best_reg;
            c_second_reg <= b_second_reg;
            c_pos_reg    <= b_pos_reg;
            c_query_reg  <= b_query_reg;
        end
    end

    assign m_tvalid    = c_valid_reg;
    assign query_index = c_query_reg;
    assign match_found = c_match_reg;
    assign best_index  = c_pos_reg;
    assign best_sum    = c_best_reg;
    assign second_sum  = c_second_reg;

endmodule

`default_nettype wire

[design/ssd_block_match_ratio_test.sv]
// The decision for the final pixel of the final candidate passes the queue, the
//   rank stage, the product stage and the output reg before m_tvalid rises.
// Throughput: one pixel pair per cycle while the queue is not full; the square-accumulate
//   front and the one-window-per-cycle ranking back both sustain it while m_tready keeps up.
// Reset: synchronous active-low aresetn clears all per-query state, counters
//   and the queue, and loads the threshold registers with their defaults.
// ----------------------------------------------------------------------------
// ssd_block_match_ratio_test
// SSD block matcher with best/second-best ratio test, APB-configured.
// ----------------------------------------------------------------------------
`default_nettype none

module ssd_block_match_ratio_test
    import ssdbm_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // APB configuration
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0]      prdata,
    output logic                       pready,
    // pixel pair stream
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [S_TDATA_W-1:0]  s_tdata,  // [7:0] query_pixel, [15:8] candidate_pixel
    input  wire logic                  s_tlast,  // last_pixel
    input  wire logic                  s_tuser,  // last_candidate
    // decision stream
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [M_TDATA_W-1:0]       m_tdata,  // [11:0] query_index, [21:12] best_index,
                                                 // [45:22] best_sum, [69:46] second_sum
    output logic                       m_tuser   // match_found
);

    logic [SUM_W-1:0]   ssd_threshold_reg;
    logic [RATIO_W-1:0] ratio_threshold_reg;
    logic               reg_sel;
    logic               wr_en;

    window_t            q_wdata;
    window_t            q_rdata;
    queue_status_t      q_status;
    logic               q_push;
    logic               q_pop;

    logic [QUERY_W-1:0] query_index;
    logic [CAND_W-1:0]  best_index;
    logic [SUM_W-1:0]   best_sum;
    logic [SUM_W-1:0]   second_sum;

    assign pready  = 1'b1;
    assign reg_sel = paddr[2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ssd_threshold_reg   <= SSD_RESET;
            ratio_threshold_reg <= RATIO_RESET;
        end else if (wr_en) begin
            case (reg_sel)
                REG_SSD_THRESHOLD: begin
                    ssd_threshold_reg <= pwdata[SUM_W-1:0];
                end
                REG_RATIO_THRESHOLD: begin
                    ratio_threshold_reg <= pwdata[RATIO_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_SSD_THRESHOLD:   prdata = APB_DATA_W'(ssd_threshold_reg);
            REG_RATIO_THRESHOLD: prdata = APB_DATA_W'(ratio_threshold_reg);
            default:             prdata = '0;
        endcase
    end

    ssdbm_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .query_pixel     (s_tdata[PIX_W-1:0]),
        .candidate_pixel (s_tdata[2*PIX_W-1:PIX_W]),
        .last_pixel      (s_tlast),
        .last_candidate  (s_tuser),
        .q_status        (q_status),
        .q_push          (q_push),
        .q_wdata         (q_wdata)
    );

    ssdbm_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wdata   (q_wdata),
        .pop     (q_pop),
        .rdata   (q_rdata),
        .status  (q_status)
    );

    ssdbm_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .q_rdata         (q_rdata),
        .q_status        (q_status),
        .q_pop           (q_pop),
        .ssd_threshold   (ssd_threshold_reg),
        .ratio_threshold (ratio_threshold_reg),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .query_index     (query_index),
        .match_found     (m_tuser),
        .best_index      (best_index),
        .best_sum        (best_sum),
        .second_sum      (second_sum)
    );

    assign m_tdata = {2'b00, second_sum, best_sum, best_index, query_index};

endmodule

`default_nettype wire

[dv/ssd_block_match_ratio_test_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ssd_block_match_ratio_test_tb
// Self-checking bench for the SSD block matcher with ratio test. Pixel-pair
// requests stream in on s_*, and a predictor keeps its own
// accumulator, best/second ranking and counters. Each decision on m_* is
// compared field by field against the oldest predicted one. Covers
// threshold and ratio boundaries, ties and saturation, then random
// queries under several flow-control phases and register settings.
// ----------------------------------------------------------------------------
`default_nettype none

module ssd_block_match_ratio_test_tb;
    import ssdbm_pkg::*;

    localparam int CLK_HALF    = 5;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_CYC  = 8;
    localparam int MAX_WIN     = 20;

    typedef struct {
        logic [QUERY_W-1:0] query_index;
        logic               match_found;
        logic [CAND_W-1:0]  best_index;
        logic [SUM_W-1:0]   best_sum;
        logic [SUM_W-1:0]   second_sum;
    } decision_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  psel      = 1'b0;
    logic                  penable   = 1'b0;
    logic                  pwrite    = 1'b0;
    logic [APB_ADDR_W-1:0] paddr     = '0;
    logic [APB_DATA_W-1:0] pwdata    = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;  // [7:0] query_pixel, [15:8] candidate_pixel
    logic                  s_tlast   = 1'b0;  // last_pixel
    logic                  s_tuser   = 1'b0;  // last_candidate
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;  // [11:0] query_index, [21:12] best_index,
                                     // [45:22] best_sum, [69:46] second_sum
    logic                  m_tuser;  // match_found

    // predictor state
    logic [SUM_W-1:0]   cfg_ssd   = SSD_RESET;
    logic [RATIO_W-1:0] cfg_ratio = RATIO_RESET;
    logic [SUM_W-1:0]   win_sum   = '0;
    logic [SUM_W-1:0]   best_acc  = SUM_MAX;
    logic [SUM_W-1:0]   second_acc = SUM_MAX;
    logic [CAND_W-1:0]  best_pos  = '0;
    logic [CAND_W-1:0]  cand_cnt  = '0;
    logic [QUERY_W-1:0] query_cnt = '0;

    decision_t decision_q[$];
    decision_t want;

    int src_idle_pct  = 0;
    int snk_stall_pct = 0;
    int error_count   = 0;
    int pairs_sent    = 0;
    int decisions_seen = 0;
    int matches_seen  = 0;
    int cycle_count   = 0;

    ssd_block_match_ratio_test DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #CLK_HALF aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d decisions pending",
                     cycle_count, decision_q.size());
            $display("ssd_block_match_ratio_test verification failed");
            $finish;
        end
    end

    always @(negedge aclk) begin
        if (snk_stall_pct == 0) begin
            m_tready <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    // result checker
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            decisions_seen++;
            if (m_tuser) matches_seen++;
            if (decision_q.size() == 0) begin
                $error("unexpected decision: query_index %0d", m_tdata[11:0]);
                error_count++;
            end else begin
                want = decision_q.pop_front();
                if (m_tdata[11:0] !== want.query_index) begin
                    $error("query_index: expected %0d, got %0d",
                           want.query_index, m_tdata[11:0]);
                    error_count++;
                end
                if (m_tuser !== want.match_found) begin
                    $error("match_found: expected %0d, got %0d",
                           want.match_found, m_tuser);
                    error_count++;
                end
                if (m_tdata[21:12] !== want.best_index) begin
                    $error("best_index: expected %0d, got %0d",
                           want.best_index, m_tdata[21:12]);
                    error_count++;
                end
                if (m_tdata[45:22] !== want.best_sum) begin
                    $error("best_sum: expected %0d, got %0d",
                           want.best_sum, m_tdata[45:22]);
                    error_count++;
                end
                if (m_tdata[69:46] !== want.second_sum) begin
                    $error("second_sum: expected %0d, got %0d",
                           want.second_sum, m_tdata[69:46]);
                    error_count++;
                end
            end
        end
    end

    // advance the matcher model by one accepted pixel pair
    task automatic rank_pair(input logic [7:0] qp, input logic [7:0] cp,
                             input logic lp, input logic lc);
        int          diff;
        logic [24:0] acc;
        logic [SUM_W-1:0] s;
        logic [PROD_W-1:0] lhs;
        logic [PROD_W-1:0] rhs;
        decision_t d;
        diff = int'(cp) - int'(qp);
        acc  = {1'b0, win_sum} + 25'(diff * diff);
        s    = acc[24] ? SUM_MAX : acc[SUM_W-1:0];
        if (!lp) begin
            win_sum = s;
            return;
        end
        if (s < best_acc) begin
            second_acc = best_acc;
            best_acc   = s;
            best_pos   = cand_cnt;
        end else if (s < second_acc) begin
            second_acc = s;
        end
        win_sum  = '0;
        cand_cnt = cand_cnt + 1'b1;
        if (!lc) return;
        lhs = {best_acc, 16'h0000};
        rhs = PROD_W'(cfg_ratio) * PROD_W'(second_acc);
        d.query_index = query_cnt;
        d.match_found = (best_acc < cfg_ssd) && (second_acc != '0) && (lhs < rhs);
        d.best_index  = best_pos;
        d.best_sum    = best_acc;
        d.second_sum  = second_acc;
        decision_q = {decision_q, d};
        best_acc   = SUM_MAX;
        second_acc = SUM_MAX;
        best_pos   = '0;
        cand_cnt   = '0;
        query_cnt  = query_cnt + 1'b1;
    endtask

    task automatic send_pair(input logic [7:0] qp, input logic [7:0] cp,
                             input logic lp, input logic lc);
        while ($urandom_range(99) < src_idle_pct) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {cp, qp};
        s_tlast  <= lp;
        s_tuser  <= lc;
        do @(posedge aclk); while (!s_tready);
        rank_pair(qp, cp, lp, lc);
        pairs_sent++;
    endtask

    // stop sending and let every pending decision drain out
    task automatic settle;
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (decision_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYC) @(posedge aclk);
    endtask

    task automatic apb_write(input logic reg_sel, input logic [APB_DATA_W-1:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (reg_sel == REG_SSD_THRESHOLD) cfg_ssd = value[SUM_W-1:0];
        else cfg_ratio = value[RATIO_W-1:0];
    endtask

    task automatic set_thresholds(input logic [SUM_W-1:0] ssd, input logic [RATIO_W-1:0] ratio);
        settle();
        apb_write(REG_SSD_THRESHOLD, APB_DATA_W'(ssd));
        apb_write(REG_RATIO_THRESHOLD, APB_DATA_W'(ratio));
    endtask

    task automatic set_flow(input int src, input int snk);
        src_idle_pct  = src;
        snk_stall_pct = snk;
    endtask

    // ties, single candidate, zero second, stray last_candidate
    task automatic test_special_cases;
        send_pair(8'd0,   8'd255, 1'b1, 1'b0);
        send_pair(8'd255, 8'd0,   1'b1, 1'b1);
        send_pair(8'd10,  8'd13,  1'b1, 1'b1);
        send_pair(8'd5,   8'd5,   1'b1, 1'b0);
        send_pair(8'd7,   8'd7,   1'b1, 1'b1);
        send_pair(8'd1,   8'd2,   1'b0, 1'b1);
        send_pair(8'd3,   8'd3,   1'b0, 1'b1);
        send_pair(8'd0,   8'd4,   1'b1, 1'b0);
        send_pair(8'd255, 8'd255, 1'b1, 1'b1);
        send_pair(8'd10,  8'd20,  1'b0, 1'b0);
        send_pair(8'd10,  8'd20,  1'b1, 1'b0);
        send_pair(8'd100, 8'd90,  1'b0, 1'b0);
        send_pair(8'd100, 8'd91,  1'b1, 1'b0);
        send_pair(8'd170, 8'd85,  1'b1, 1'b1);
    endtask

    // threshold boundaries: strict compare on both tests
    task automatic test_thresholds;
        set_thresholds(24'd0, RATIO_RESET);
        send_pair(8'd10, 8'd13, 1'b1, 1'b1);
        set_thresholds(24'd10, RATIO_RESET);
        send_pair(8'd10, 8'd13, 1'b1, 1'b1);
        set_thresholds(24'd9, 16'd0);
        send_pair(8'd10, 8'd13, 1'b1, 1'b1);
        set_thresholds(SUM_MAX, 16'd32768);
        // best 1, second 2: ratio exactly one half, no match
        send_pair(8'd40, 8'd41, 1'b1, 1'b0);
        send_pair(8'd40, 8'd41, 1'b0, 1'b0);
        send_pair(8'd40, 8'd39, 1'b1, 1'b1);
        // best 1, second 4: match
        send_pair(8'd40, 8'd41, 1'b1, 1'b0);
        send_pair(8'd40, 8'd42, 1'b1, 1'b1);
        set_thresholds(SUM_MAX, 16'hFFFF);
        send_pair(8'd0, 8'd255, 1'b1, 1'b0);
        send_pair(8'd0, 8'd254, 1'b1, 1'b1);
    endtask

    task automatic test_saturation;
        for (int i = 0; i < 259; i++) send_pair(8'd0, 8'd255, 1'b0, 1'b0);
        send_pair(8'd255, 8'd0, 1'b1, 1'b0);
        send_pair(8'd9, 8'd200, 1'b1, 1'b1);
    endtask

    // well-formed queries with random content, plus stray last_candidate noise
    task automatic test_random_queries(input int n_pairs);
        logic [7:0] qwin[MAX_WIN];
        logic [7:0] cwin[MAX_WIN];
        int stop_at;
        int n_cand;
        int n_pix;
        int style;
        int v;
        logic lp;
        logic lc;
        stop_at = pairs_sent + n_pairs;
        while (pairs_sent < stop_at) begin
            n_cand = ($urandom_range(9) == 0) ? 1 : $urandom_range(2, 6);
            n_pix  = ($urandom_range(19) == 0) ? MAX_WIN : $urandom_range(1, 9);
            for (int p = 0; p < n_pix; p++) begin
                qwin[p] = 8'($urandom);
                cwin[p] = 8'($urandom);
            end
            for (int k = 0; k < n_cand; k++) begin
                style = $urandom_range(3);
                for (int p = 0; p < n_pix; p++) begin
                    case (style)
                        0: begin
                            cwin[p] = 8'($urandom);
                        end
                        1: begin
                            v = int'(qwin[p]) + $urandom_range(0, 6) - 3;
                            cwin[p] = (v < 0) ? 8'd0 : (v > 255) ? 8'd255 : 8'(v);
                        end
                        2: begin
                            cwin[p] = qwin[p];
                        end
                        default: begin
                            // repeat the previous candidate: equal sums
                        end
                    endcase
                    lp = (p == n_pix - 1);
                    lc = lp ? (k == n_cand - 1) : ($urandom_range(19) == 0);
                    send_pair(qwin[p], cwin[p], lp, lc);
                end
            end
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        set_flow(0, 0);
        test_special_cases();
        test_thresholds();
        set_flow(22, 22);
        test_saturation();

        set_thresholds(SSD_RESET, RATIO_RESET);
        set_flow(0, 0);
        test_random_queries(120);
        set_thresholds(24'd0, 16'hFFFF);
        set_flow(50, 0);
        test_random_queries(120);
        set_thresholds(SUM_MAX, 16'd0);
        set_flow(0, 50);
        test_random_queries(120);
        set_thresholds(24'($urandom_range(200, 20000)), 16'($urandom_range(30000, 60000)));
        set_flow(22, 22);
        test_random_queries(120);

        settle();
        $display("Sent %0d pixel pairs; checked %0d decisions, %0d of them matches,",
                 pairs_sent, decisions_seen, matches_seen);
        $display("over four flow-control phases and a range of threshold settings.");
        if (error_count == 0) begin
            $display("ssd_block_match_ratio_test verification clean");
        end else begin
            $display("ssd_block_match_ratio_test verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
